// ===== rtl/ptsc_pkg.sv =====
package ptsc_pkg;

   typedef logic [31:0]        time_type;
   typedef logic [15:0]        word_type;
   typedef logic signed [15:0] sample_type;
   typedef logic [1:0]         action_type;
   typedef logic [1:0]         csr_index_type;

   // request action codes
   localparam action_type ACT_TICK  = 2'd0;
   localparam action_type ACT_START = 2'd1;
   localparam action_type ACT_STOP  = 2'd2;

   // configuration register indexes
   localparam csr_index_type CSR_TRIAL_COUNT = 2'd0;
   localparam csr_index_type CSR_INTERVAL    = 2'd1;
   localparam csr_index_type CSR_WINDOW_MS   = 2'd2;

   // result kinds
   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_TRIGGER = 1'b1;

   localparam word_type TRIAL_COUNT_RESET = 16'd1;
   localparam word_type INTERVAL_RESET    = 16'd1000;
   localparam word_type WINDOW_MS_RESET   = 16'd100;

   // result queue
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

   typedef struct packed {
      logic     kind;
      word_type trial_number;
      time_type event_time;
      word_type raw_min;
      word_type raw_max;
      word_type raw_swing;
      word_type centered_swing;
      word_type best_raw_swing;
      word_type best_centered_swing;
      word_type completed_count;
      logic     session_done;
      logic     last;
   } result_type;

   // wrap-safe time compare: a is at or after b
   function automatic logic at_or_after(input time_type a, input time_type b);
      time_type diff;
      diff = a - b;
      return ~diff[31];
   endfunction

endpackage

// ===== rtl/periodic_trial_swing_capture_core.sv =====
// Periodic trial swing capture. A start request arms a session that fires
// trial triggers every trigger interval, the first one due at the start's
// time; a stop request disarms it. Tick requests carry the time and one raw and one
// centered sample: samples inside the open trial's window widen its min/max,
// the first tick at or past the window end produces a trial report, and a
// tick at or past the next trigger time opens the next trial and produces a
// trigger result. A tick can give up to two results (report, then trigger);
// rsp_last marks the final one. All the work for a request is done in the
// accept cycle and results go to a four-entry result queue, the first one
// offered on the next cycle if the queue was empty, so a request is
// accepted every cycle while the queue has room for two results; the
// sustained rate is one request per cycle, bounded by the single result
// port when ticks produce two results. Configuration registers are sampled
// only by a start request.
module periodic_trial_swing_capture_core (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ptsc_pkg::action_type     req_action,
   input  ptsc_pkg::time_type       req_now_ms,
   input  ptsc_pkg::word_type       req_raw_sample,
   input  ptsc_pkg::sample_type     req_centered_sample,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_kind,
   output ptsc_pkg::word_type       rsp_trial_number,
   output ptsc_pkg::time_type       rsp_event_time,
   output ptsc_pkg::word_type       rsp_raw_min,
   output ptsc_pkg::word_type       rsp_raw_max,
   output ptsc_pkg::word_type       rsp_raw_swing,
   output ptsc_pkg::word_type       rsp_centered_swing,
   output ptsc_pkg::word_type       rsp_best_raw_swing,
   output ptsc_pkg::word_type       rsp_best_centered_swing,
   output ptsc_pkg::word_type       rsp_completed_count,
   output logic                     rsp_session_done,
   output logic                     rsp_last,
   // configuration write port
   input  logic                     csr_wr_en,
   input  ptsc_pkg::csr_index_type  csr_index,
   input  ptsc_pkg::word_type       csr_wdata
);
   import ptsc_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   word_type trial_count_ff, interval_ff, window_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trial_count_ff <= TRIAL_COUNT_RESET;
         interval_ff    <= INTERVAL_RESET;
         window_ms_ff   <= WINDOW_MS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIAL_COUNT: trial_count_ff <= csr_wdata;
            CSR_INTERVAL:    interval_ff    <= csr_wdata;
            CSR_WINDOW_MS:   window_ms_ff   <= csr_wdata;
            default: ;       // unused index: write is dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Session state
   // ------------------------------------------------------------------
   logic       active_ff, active_in;
   word_type   trial_index_ff, trial_index_in;
   time_type   window_start_ff, window_start_in;
   time_type   window_end_ff, window_end_in;
   logic       closed_ff, closed_in;
   time_type   next_trigger_ff, next_trigger_in;
   word_type   eff_window_ff, eff_window_in;
   word_type   sess_trials_ff, sess_trials_in;
   word_type   sess_period_ff, sess_period_in;
   word_type   raw_min_ff, raw_min_in;
   word_type   raw_max_ff, raw_max_in;
   sample_type cen_min_ff, cen_min_in;
   sample_type cen_max_ff, cen_max_in;
   word_type   done_count_ff, done_count_in;
   word_type   best_raw_ff, best_raw_in;
   logic [16:0] best_cen_ff, best_cen_in;

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   result_type             rq_mem_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]       rq_wr_ptr_ff, rq_rd_ptr_ff;
   logic [RQ_CW-1:0]       rq_count_ff, rq_count_in;

   logic req_take, rsp_take;
   assign req_stall = (rq_count_ff > RQ_CW'(RQ_DEPTH - 2));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (rq_count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // ------------------------------------------------------------------
   // Per-request logic
   // ------------------------------------------------------------------
   word_type   start_trials, start_period, start_window;
   logic       is_tick, trial_open, in_window, do_close, do_trigger;
   logic       active_after_close;
   word_type   raw_min_w, raw_max_w;
   sample_type cen_min_w, cen_max_w;
   word_type   raw_swing;
   logic [16:0] cen_swing;
   word_type   done_next, best_raw_next;
   logic [16:0] best_cen_next;
   result_type report_res, trigger_res, res0, res1;
   logic       push0, push1;

   always_comb begin
      // start: zero registers count as one, window kept below the period unless the period is one
      start_trials = (trial_count_ff != '0) ? trial_count_ff : 16'd1;
      start_period = (interval_ff != '0) ? interval_ff : 16'd1;
      start_window = (window_ms_ff != '0) ? window_ms_ff : 16'd1;
      if (start_window >= start_period) begin
         start_window = (start_period > 16'd1) ? start_period - 16'd1 : start_period;
      end

      is_tick    = req_take && (req_action == ACT_TICK) && active_ff;
      trial_open = (trial_index_ff != '0) && !closed_ff;
      in_window  = trial_open && at_or_after(req_now_ms, window_start_ff)
                   && at_or_after(window_end_ff, req_now_ms);

      // widen the open trial's extremes
      raw_min_w = raw_min_ff;
      raw_max_w = raw_max_ff;
      cen_min_w = cen_min_ff;
      cen_max_w = cen_max_ff;
      if (in_window) begin
         if (req_raw_sample < raw_min_ff)      raw_min_w = req_raw_sample;
         if (req_raw_sample > raw_max_ff)      raw_max_w = req_raw_sample;
         if (req_centered_sample < cen_min_ff) cen_min_w = req_centered_sample;
         if (req_centered_sample > cen_max_ff) cen_max_w = req_centered_sample;
      end

      // window end passed: close and report
      do_close      = is_tick && trial_open && at_or_after(req_now_ms, window_end_ff);
      raw_swing     = raw_max_w - raw_min_w;
      cen_swing     = {cen_max_w[15], cen_max_w} - {cen_min_w[15], cen_min_w};
      done_next     = done_count_ff + 16'd1;
      best_raw_next = (raw_swing > best_raw_ff) ? raw_swing : best_raw_ff;
      best_cen_next = (cen_swing > best_cen_ff) ? cen_swing : best_cen_ff;
      active_after_close = active_ff;
      if (do_close && (trial_index_ff >= sess_trials_ff)) begin
         active_after_close = 1'b0;
      end

      // trigger due: open the next trial
      do_trigger = is_tick && active_after_close
                   && at_or_after(req_now_ms, next_trigger_ff)
                   && (trial_index_ff < sess_trials_ff);

      report_res = '{
         kind:                KIND_REPORT,
         trial_number:        trial_index_ff,
         event_time:          req_now_ms,
         raw_min:             raw_min_w,
         raw_max:             raw_max_w,
         raw_swing:           raw_swing,
         centered_swing:      cen_swing[15:0],
         best_raw_swing:      best_raw_next,
         best_centered_swing: best_cen_next[15:0],
         completed_count:     done_next,
         session_done:        !active_after_close,
         last:                !do_trigger
      };
      trigger_res = '0;
      trigger_res.kind         = KIND_TRIGGER;
      trigger_res.trial_number = trial_index_ff + 16'd1;
      trigger_res.event_time   = next_trigger_ff;
      trigger_res.last         = 1'b1;

      push0 = do_close || do_trigger;
      push1 = do_close && do_trigger;
      res0  = do_close ? report_res : trigger_res;
      res1  = trigger_res;

      // next state, default hold
      active_in       = active_ff;
      trial_index_in  = trial_index_ff;
      window_start_in = window_start_ff;
      window_end_in   = window_end_ff;
      closed_in       = closed_ff;
      next_trigger_in = next_trigger_ff;
      eff_window_in   = eff_window_ff;
      sess_trials_in  = sess_trials_ff;
      sess_period_in  = sess_period_ff;
      raw_min_in      = raw_min_ff;
      raw_max_in      = raw_max_ff;
      cen_min_in      = cen_min_ff;
      cen_max_in      = cen_max_ff;
      done_count_in   = done_count_ff;
      best_raw_in     = best_raw_ff;
      best_cen_in     = best_cen_ff;

      if (req_take && (req_action == ACT_START)) begin
         sess_trials_in  = start_trials;
         sess_period_in  = start_period;
         eff_window_in   = start_window;
         active_in       = 1'b1;
         trial_index_in  = '0;
         window_start_in = '0;
         window_end_in   = '0;
         closed_in       = 1'b0;
         next_trigger_in = req_now_ms;
         raw_min_in      = '0;
         raw_max_in      = '0;
         cen_min_in      = '0;
         cen_max_in      = '0;
         done_count_in   = '0;
         best_raw_in     = '0;
         best_cen_in     = '0;
      end else if (req_take && (req_action == ACT_STOP)) begin
         active_in = 1'b0;
      end else if (is_tick) begin
         raw_min_in = raw_min_w;
         raw_max_in = raw_max_w;
         cen_min_in = cen_min_w;
         cen_max_in = cen_max_w;
         if (do_close) begin
            done_count_in = done_next;
            best_raw_in   = best_raw_next;
            best_cen_in   = best_cen_next;
            closed_in     = 1'b1;
            active_in     = active_after_close;
         end
         if (do_trigger) begin
            trial_index_in  = trial_index_ff + 16'd1;
            window_start_in = next_trigger_ff;
            window_end_in   = next_trigger_ff + {16'd0, eff_window_ff};
            closed_in       = 1'b0;
            next_trigger_in = next_trigger_ff + {16'd0, sess_period_ff};
            raw_min_in      = req_raw_sample;
            raw_max_in      = req_raw_sample;
            cen_min_in      = req_centered_sample;
            cen_max_in      = req_centered_sample;
         end
      end

      rq_count_in = rq_count_ff + RQ_CW'(push0) + RQ_CW'(push1) - RQ_CW'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         trial_index_ff  <= '0;
         window_start_ff <= '0;
         window_end_ff   <= '0;
         closed_ff       <= 1'b0;
         next_trigger_ff <= '0;
         eff_window_ff   <= 16'd1;
         sess_trials_ff  <= TRIAL_COUNT_RESET;
         sess_period_ff  <= INTERVAL_RESET;
         raw_min_ff      <= '0;
         raw_max_ff      <= '0;
         cen_min_ff      <= '0;
         cen_max_ff      <= '0;
         done_count_ff   <= '0;
         best_raw_ff     <= '0;
         best_cen_ff     <= '0;
         rq_wr_ptr_ff    <= '0;
         rq_rd_ptr_ff    <= '0;
         rq_count_ff     <= '0;
      end else begin
         active_ff       <= active_in;
         trial_index_ff  <= trial_index_in;
         window_start_ff <= window_start_in;
         window_end_ff   <= window_end_in;
         closed_ff       <= closed_in;
         next_trigger_ff <= next_trigger_in;
         eff_window_ff   <= eff_window_in;
         sess_trials_ff  <= sess_trials_in;
         sess_period_ff  <= sess_period_in;
         raw_min_ff      <= raw_min_in;
         raw_max_ff      <= raw_max_in;
         cen_min_ff      <= cen_min_in;
         cen_max_ff      <= cen_max_in;
         done_count_ff   <= done_count_in;
         best_raw_ff     <= best_raw_in;
         best_cen_ff     <= best_cen_in;
         rq_wr_ptr_ff    <= rq_wr_ptr_ff + RQ_AW'(push0) + RQ_AW'(push1);
         if (rsp_take) begin
            rq_rd_ptr_ff <= rq_rd_ptr_ff + RQ_AW'(1);
         end
         rq_count_ff     <= rq_count_in;
      end
   end

   // queue payload: no reset needed
   always_ff @(posedge clock) begin
      if (push0) begin
         rq_mem_ff[rq_wr_ptr_ff] <= res0;
      end
      if (push1) begin
         rq_mem_ff[rq_wr_ptr_ff + RQ_AW'(1)] <= res1;
      end
   end

   // head of queue drives the result ports
   result_type head;
   assign head = rq_mem_ff[rq_rd_ptr_ff];

   assign rsp_kind                = head.kind;
   assign rsp_trial_number        = head.trial_number;
   assign rsp_event_time          = head.event_time;
   assign rsp_raw_min             = head.raw_min;
   assign rsp_raw_max             = head.raw_max;
   assign rsp_raw_swing           = head.raw_swing;
   assign rsp_centered_swing      = head.centered_swing;
   assign rsp_best_raw_swing      = head.best_raw_swing;
   assign rsp_best_centered_swing = head.best_centered_swing;
   assign rsp_completed_count     = head.completed_count;
   assign rsp_session_done        = head.session_done;
   assign rsp_last                = head.last;

endmodule

// ===== dv/periodic_trial_swing_capture_checker.sv =====
`timescale 1ns / 100ps

module periodic_trial_swing_capture_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  ptsc_pkg::action_type    req_action,
   input  ptsc_pkg::time_type      req_now_ms,
   input  ptsc_pkg::word_type      req_raw_sample,
   input  ptsc_pkg::sample_type    req_centered_sample,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_kind,
   input  ptsc_pkg::word_type      rsp_trial_number,
   input  ptsc_pkg::time_type      rsp_event_time,
   input  ptsc_pkg::word_type      rsp_raw_min,
   input  ptsc_pkg::word_type      rsp_raw_max,
   input  ptsc_pkg::word_type      rsp_raw_swing,
   input  ptsc_pkg::word_type      rsp_centered_swing,
   input  ptsc_pkg::word_type      rsp_best_raw_swing,
   input  ptsc_pkg::word_type      rsp_best_centered_swing,
   input  ptsc_pkg::word_type      rsp_completed_count,
   input  logic                    rsp_session_done,
   input  logic                    rsp_last,
   input  logic                    csr_wr_en,
   input  ptsc_pkg::csr_index_type csr_index,
   input  ptsc_pkg::word_type      csr_wdata,
   output int unsigned             mismatch_count,
   output int unsigned             awaited_count
);
   import ptsc_pkg::*;

   // register file as last written
   word_type   reg_trials;
   word_type   reg_period;
   word_type   reg_window;

   // session state
   logic       armed;
   word_type   trial_no;
   time_type   open_at;
   time_type   close_at;
   logic       closed;
   time_type   due_at;
   word_type   span;
   word_type   raw_lo;
   word_type   raw_hi;
   sample_type cen_lo;
   sample_type cen_hi;
   word_type   finished;
   word_type   best_raw;
   logic [16:0] best_cen;
   word_type   sess_trials;
   word_type   sess_period;

   result_type  awaited_results[$];
   int unsigned faults = 0;

   // wrap-safe: a is at or after b
   function automatic logic not_before(input time_type a, input time_type b);
      time_type gap;
      gap = a - b;
      return !gap[31];
   endfunction

   function automatic string show(input result_type r);
      return $sformatf({"kind %0d trial %0d time %h raw %0d..%0d swing %0d/%0d",
                        " best %0d/%0d count %0d done %b last %b"},
                       r.kind, r.trial_number, r.event_time, r.raw_min, r.raw_max,
                       r.raw_swing, r.centered_swing, r.best_raw_swing,
                       r.best_centered_swing, r.completed_count, r.session_done,
                       r.last);
   endfunction

   task automatic advance_trials(input action_type act, input time_type now,
                                 input word_type raw, input sample_type cen);
      word_type    t;
      word_type    p;
      word_type    w;
      word_type    rswing;
      logic [16:0] cswing;
      result_type  rep;
      result_type  trg;
      bit          have_rep;
      bit          have_trg;
      have_rep = 1'b0;
      have_trg = 1'b0;
      rep = '0;
      trg = '0;
      case (act)
         ACT_START: begin
            t = (reg_trials == 0) ? 16'd1 : reg_trials;
            p = (reg_period == 0) ? 16'd1 : reg_period;
            w = (reg_window == 0) ? 16'd1 : reg_window;
            if (w >= p) w = (p > 16'd1) ? p - 16'd1 : p;
            sess_trials = t;
            sess_period = p;
            span = w;
            armed = 1'b1;
            trial_no = '0;
            open_at = '0;
            close_at = '0;
            closed = 1'b0;
            due_at = now;
            raw_lo = '0;
            raw_hi = '0;
            cen_lo = '0;
            cen_hi = '0;
            finished = '0;
            best_raw = '0;
            best_cen = '0;
         end
         ACT_STOP: armed = 1'b0;
         ACT_TICK: if (armed) begin
            if (trial_no != 0 && !closed && not_before(now, open_at) &&
                not_before(close_at, now)) begin
               if (raw < raw_lo) raw_lo = raw;
               if (raw > raw_hi) raw_hi = raw;
               if (cen < cen_lo) cen_lo = cen;
               if (cen > cen_hi) cen_hi = cen;
            end
            if (trial_no != 0 && !closed && not_before(now, close_at)) begin
               rswing = raw_hi - raw_lo;
               cswing = {cen_hi[15], cen_hi} - {cen_lo[15], cen_lo};
               finished = finished + 16'd1;
               if (rswing > best_raw) best_raw = rswing;
               if (cswing > best_cen) best_cen = cswing;
               closed = 1'b1;
               if (trial_no >= sess_trials) armed = 1'b0;
               rep.kind = KIND_REPORT;
               rep.trial_number = trial_no;
               rep.event_time = now;
               rep.raw_min = raw_lo;
               rep.raw_max = raw_hi;
               rep.raw_swing = rswing;
               rep.centered_swing = cswing[15:0];
               rep.best_raw_swing = best_raw;
               rep.best_centered_swing = best_cen[15:0];
               rep.completed_count = finished;
               rep.session_done = !armed;
               have_rep = 1'b1;
            end
            if (armed && not_before(now, due_at) && trial_no < sess_trials) begin
               trial_no = trial_no + 16'd1;
               open_at = due_at;
               close_at = due_at + time_type'(span);
               closed = 1'b0;
               trg.kind = KIND_TRIGGER;
               trg.trial_number = trial_no;
               trg.event_time = due_at;
               due_at = due_at + time_type'(sess_period);
               raw_lo = raw;
               raw_hi = raw;
               cen_lo = cen;
               cen_hi = cen;
               have_trg = 1'b1;
            end
         end
         default: ;
      endcase
      if (have_trg) trg.last = 1'b1;
      else rep.last = have_rep;
      if (have_rep) awaited_results.push_back(rep);
      if (have_trg) awaited_results.push_back(trg);
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.kind = rsp_kind;
      got.trial_number = rsp_trial_number;
      got.event_time = rsp_event_time;
      got.raw_min = rsp_raw_min;
      got.raw_max = rsp_raw_max;
      got.raw_swing = rsp_raw_swing;
      got.centered_swing = rsp_centered_swing;
      got.best_raw_swing = rsp_best_raw_swing;
      got.best_centered_swing = rsp_best_centered_swing;
      got.completed_count = rsp_completed_count;
      got.session_done = rsp_session_done;
      got.last = rsp_last;
      if (awaited_results.size() == 0) begin
         if (faults < 10) $display("%0t: result with nothing awaited: %s", $time, show(got));
         faults++;
      end else begin
         want = awaited_results.pop_front();
         if (got !== want) begin
            if (faults < 10) begin
               $display("%0t: result mismatch", $time);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
            faults++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reg_trials = TRIAL_COUNT_RESET;
         reg_period = INTERVAL_RESET;
         reg_window = WINDOW_MS_RESET;
         armed = 1'b0;
         trial_no = '0;
         open_at = '0;
         close_at = '0;
         closed = 1'b0;
         due_at = '0;
         span = 16'd1;
         raw_lo = '0;
         raw_hi = '0;
         cen_lo = '0;
         cen_hi = '0;
         finished = '0;
         best_raw = '0;
         best_cen = '0;
         sess_trials = 16'd1;
         sess_period = 16'd1000;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRIAL_COUNT: reg_trials = csr_wdata;
               CSR_INTERVAL:    reg_period = csr_wdata;
               CSR_WINDOW_MS:   reg_window = csr_wdata;
               default: ;
            endcase
         end
         // requests first: a result never leaves in its request's own cycle
         if (req_valid && !req_stall)
            advance_trials(req_action, req_now_ms, req_raw_sample, req_centered_sample);
         if (rsp_valid && !rsp_stall) check_result();
      end
      mismatch_count <= faults;
      awaited_count <= awaited_results.size();
   end

endmodule

// ===== dv/periodic_trial_swing_capture_core_test.sv =====
`timescale 1ns / 100ps

module periodic_trial_swing_capture_core_test;
   import ptsc_pkg::*;

   // codes with no meaning to the block; it must ignore them
   localparam action_type    ACT_SPARE = 2'd3;
   localparam csr_index_type CSR_SPARE = 2'd3;

   localparam int unsigned RANDOM_ITEMS   = 650;
   localparam int unsigned CALM_ITEMS     = 100;  // tail of the run with no idling
   localparam int unsigned SETTLE_CYCLES  = 8;    // result queue drain margin
   localparam int unsigned HOLD_CYCLES    = 64;   // long receiver hold-off
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic       clock;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   action_type req_action = ACT_TICK;
   time_type   req_now_ms = '0;
   word_type   req_raw_sample = '0;
   sample_type req_centered_sample = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   word_type   rsp_trial_number;
   time_type   rsp_event_time;
   word_type   rsp_raw_min;
   word_type   rsp_raw_max;
   word_type   rsp_raw_swing;
   word_type   rsp_centered_swing;
   word_type   rsp_best_raw_swing;
   word_type   rsp_best_centered_swing;
   word_type   rsp_completed_count;
   logic       rsp_session_done;
   logic       rsp_last;

   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_TRIAL_COUNT;
   word_type      csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned awaited_count;

   // stimulus knobs shared between the sender and receiver processes
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;
   bit          squeeze_req = 1'b0;
   bit          squeeze_done = 1'b0;
   int unsigned cur_period = 1000;  // programmed period, sizes the time steps
   int unsigned sent = 0;
   int unsigned quiet_cycles = 0;

   periodic_trial_swing_capture_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_now_ms              (req_now_ms),
      .req_raw_sample          (req_raw_sample),
      .req_centered_sample     (req_centered_sample),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_kind                (rsp_kind),
      .rsp_trial_number        (rsp_trial_number),
      .rsp_event_time          (rsp_event_time),
      .rsp_raw_min             (rsp_raw_min),
      .rsp_raw_max             (rsp_raw_max),
      .rsp_raw_swing           (rsp_raw_swing),
      .rsp_centered_swing      (rsp_centered_swing),
      .rsp_best_raw_swing      (rsp_best_raw_swing),
      .rsp_best_centered_swing (rsp_best_centered_swing),
      .rsp_completed_count     (rsp_completed_count),
      .rsp_session_done        (rsp_session_done),
      .rsp_last                (rsp_last),
      .csr_wr_en               (csr_wr_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   periodic_trial_swing_capture_checker trial_check (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_now_ms              (req_now_ms),
      .req_raw_sample          (req_raw_sample),
      .req_centered_sample     (req_centered_sample),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_kind                (rsp_kind),
      .rsp_trial_number        (rsp_trial_number),
      .rsp_event_time          (rsp_event_time),
      .rsp_raw_min             (rsp_raw_min),
      .rsp_raw_max             (rsp_raw_max),
      .rsp_raw_swing           (rsp_raw_swing),
      .rsp_centered_swing      (rsp_centered_swing),
      .rsp_best_raw_swing      (rsp_best_raw_swing),
      .rsp_best_centered_swing (rsp_best_centered_swing),
      .rsp_completed_count     (rsp_completed_count),
      .rsp_session_done        (rsp_session_done),
      .rsp_last                (rsp_last),
      .csr_wr_en               (csr_wr_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .mismatch_count          (mismatch_count),
      .awaited_count           (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Samples: mostly random, with the range ends showing up often.
   function automatic word_type pick_raw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'hFFFF;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic sample_type pick_centered();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic word_type pick_extreme();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return 16'd1;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Session start time: often just short of a wrap of the counter or of the
   // sign boundary, so that windows and triggers straddle it.
   function automatic time_type pick_stamp();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFFF - $urandom_range(0, cur_period * 4);
         1: return 32'h7FFF_FFFF - $urandom_range(0, cur_period * 4);
         default: return $urandom;
      endcase
   endfunction

   // Next tick time: mostly small forward steps so trials open and close in
   // order, some jumps past whole periods, some steps back, rare wild values.
   function automatic time_type next_stamp(input time_type stamp);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 72) return stamp + $urandom_range(0, cur_period / 2 + 1);
      else if (roll < 88) return stamp + $urandom_range(cur_period / 2, cur_period * 2);
      else if (roll < 95) return stamp - $urandom_range(1, cur_period);
      else return $urandom;
   endfunction

   // Present one request and hold it until the block takes it. Valid stays
   // high afterwards, unless a random sender gap drops it, so back-to-back requests need
   // no extra edge; the caller lowers it through settle() when the stream pauses.
   task automatic offer_request(input action_type act, input time_type stamp,
                                input word_type raw, input sample_type cen);
      req_valid <= 1'b1;
      req_action <= act;
      req_now_ms <= stamp;
      req_raw_sample <= raw;
      req_centered_sample <= cen;
      do @(posedge clock); while (req_stall);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stop sending and let every awaited result come out, plus a margin for
   // requests that produce nothing but may still be in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle (after settle). Registers go in on
   // consecutive edges with the write enable held high.
   task automatic load_registers(input word_type trials, input word_type period,
                                 input word_type window, input bit touch_spare);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TRIAL_COUNT;
      csr_wdata <= trials;
      @(posedge clock);
      csr_index <= CSR_INTERVAL;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_WINDOW_MS;
      csr_wdata <= window;
      @(posedge clock);
      if (touch_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= word_type'($urandom);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_period = (period == 0) ? 1 : period;
   endtask

   // One session: a start, then mostly well-ordered ticks, with some stops,
   // restarts and unused codes mixed in.
   task automatic play_session(input int unsigned budget);
      time_type    stamp;
      int unsigned roll;
      int unsigned n;
      stamp = pick_stamp();
      offer_request(ACT_START, stamp, pick_raw(), pick_centered());
      sent++;
      for (n = 0; n < budget; n++) begin
         if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            offer_request(ACT_STOP, $urandom, pick_raw(), pick_centered());
            sent++;
         end else if (roll < 6) begin
            // ignored by the block, so not counted
            offer_request(ACT_SPARE, $urandom, pick_raw(), pick_centered());
         end else if (roll < 8) begin
            stamp = next_stamp(stamp);
            offer_request(ACT_START, stamp, pick_raw(), pick_centered());
            sent++;
         end else begin
            stamp = next_stamp(stamp);
            offer_request(ACT_TICK, stamp, pick_raw(), pick_centered());
            sent++;
         end
      end
   endtask

   // Receiver: stall bursts between free runs, plus one long hold-off on
   // request from the stimulus so the result queue backs up.
   initial begin : receiver
      @(posedge clock);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            squeeze_done = 1'b1;
            @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      word_type    trials;
      word_type    period;
      word_type    window;
      int unsigned roll;
      time_type    stamp;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: registers still at their reset values ---
      offer_request(ACT_TICK, 32'd0, 16'd0, 16'sd0);              // tick with no session
      offer_request(ACT_STOP, 32'hFFFF_FFFF, 16'hFFFF, -16'sd1);  // stop with no session
      offer_request(ACT_SPARE, 32'h5555_AAAA, 16'h5A5A, 16'sh7FFF);
      offer_request(ACT_START, 32'd0, 16'd0, 16'sd0);
      offer_request(ACT_TICK, 32'd0, 16'hFFFF, 16'sh7FFF);        // trigger, seeds the window
      offer_request(ACT_TICK, 32'd50, 16'd0, 16'sh8000);          // full-range swing
      offer_request(ACT_TICK, 32'd100, 16'h1234, 16'sd0);         // last trial closes, no trigger

      // zero registers act as one; the unused index must change nothing
      settle();
      load_registers(16'd0, 16'd0, 16'd0, 1'b1);
      offer_request(ACT_START, 32'hFFFF_FFFF, 16'hAAAA, 16'sh5555);
      offer_request(ACT_TICK, 32'hFFFF_FFFF, 16'h8000, 16'sd1);
      offer_request(ACT_TICK, 32'd0, 16'h7FFF, -16'sd2);          // window end past the wrap

      // largest registers: window clamped one below the period
      settle();
      load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      offer_request(ACT_START, 32'h8000_0000, 16'd7, 16'sd7);
      offer_request(ACT_TICK, 32'h8000_0000, 16'd100, -16'sd100);
      offer_request(ACT_TICK, 32'h8000_FFFE, 16'd300, 16'sd300);  // report, session goes on
      offer_request(ACT_TICK, 32'h8000_FFFF, 16'd5, 16'sd5);      // second trigger
      offer_request(ACT_TICK, 32'h8001_FFFD, 16'd9, -16'sd9);     // one before the third is due
      offer_request(ACT_STOP, 32'h8001_FFFE, 16'd0, 16'sd0);
      offer_request(ACT_TICK, 32'h8001_FFFE, 16'd1, 16'sd1);      // ignored after stop
      // restart while active, then a tick that both reports and triggers
      offer_request(ACT_START, 32'h0000_1000, 16'd2, 16'sd2);
      offer_request(ACT_TICK, 32'h0000_1000, 16'd3, 16'sd3);
      offer_request(ACT_START, 32'h0000_2000, 16'd4, 16'sd4);
      offer_request(ACT_TICK, 32'h0000_2000, 16'd11, -16'sd11);
      offer_request(ACT_TICK, 32'h0001_1FFF, 16'd22, 16'sd22);

      // --- back-pressure: dense results while the receiver holds off ---
      settle();
      load_registers(16'd20, 16'd3, 16'd1, 1'b0);
      sender_gaps = 1'b0;
      stamp = pick_stamp();
      offer_request(ACT_START, stamp, pick_raw(), pick_centered());
      squeeze_req = 1'b1;
      repeat (80) begin
         offer_request(ACT_TICK, stamp, pick_raw(), pick_centered());
         stamp = stamp + 32'd1;
      end
      sender_gaps = 1'b1;

      // --- random sessions over a spread of register settings ---
      while (sent < RANDOM_ITEMS) begin
         settle();
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            trials = pick_extreme();
            period = pick_extreme();
            window = pick_extreme();
         end else if (roll == 1) begin
            trials = word_type'($urandom_range(1, 4));
            period = word_type'($urandom_range(100, 65535));
            window = word_type'($urandom_range(1, 65535));
         end else begin
            trials = word_type'($urandom_range(1, 8));
            period = word_type'($urandom_range(1, 40));
            // reaches past the period too
            window = word_type'($urandom_range(0, period + 2));
         end
         load_registers(trials, period, window, $urandom_range(0, 7) == 0);
         repeat ($urandom_range(1, 3)) play_session($urandom_range(8, 40));
      end

      settle();
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
